// File: rtl/core/alubcd_pkg.sv
// Package for the 8-bit ALU with decimal mode.
// Holds the operation codes, status bit positions and the adder result type.
// No dependencies.
package alubcd_pkg;

  typedef enum logic [3:0] {
    OP_ADC    = 4'd0,
    OP_SBC    = 4'd1,
    OP_CMP    = 4'd2,
    OP_BIT    = 4'd3,
    OP_BITIMM = 4'd4,
    OP_ASL    = 4'd5,
    OP_LSR    = 4'd6,
    OP_ROL    = 4'd7,
    OP_ROR    = 4'd8,
    OP_ORA    = 4'd9,
    OP_AND    = 4'd10,
    OP_EOR    = 4'd11,
    OP_INC    = 4'd12,
    OP_DEC    = 4'd13,
    OP_TRB    = 4'd14,
    OP_TSB    = 4'd15
  } alu_op_e;

  // status byte bit positions
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  typedef struct packed {
    logic [7:0] res;
    logic       c;
    logic       v;
  } addsub_t;

endpackage

// File: rtl/core/alubcd_addsub.sv
// Add/subtract unit with binary and decimal modes (ADC, SBC).
// Depends on alubcd_pkg for addsub_t.
module alubcd_addsub (
  input  logic              sub_i,
  input  logic              dec_i,
  input  logic              cin_i,
  input  logic [7:0]        a_i,
  input  logic [7:0]        v_i,
  output alubcd_pkg::addsub_t out_o
);
  import alubcd_pkg::*;

  logic [8:0] bin_sum;
  logic [8:0] bin_dif;
  logic [7:0] bin_dif_r;
  logic [5:0] add_lo;
  logic [5:0] add_lo_adj;
  logic [4:0] add_hi;
  logic       add_cy;
  logic [3:0] add_hi_r;
  logic [7:0] dec_sum;
  logic [4:0] sub_lo;
  logic [4:0] sub_hi;
  logic [3:0] sub_lo_r;
  logic [3:0] sub_hi_r;
  logic [7:0] add_r;

  // binary paths
  assign bin_sum   = {1'b0, a_i} + {1'b0, v_i} + {8'd0, cin_i};
  assign bin_dif   = {1'b0, a_i} - {1'b0, v_i} - {8'd0, ~cin_i};
  assign bin_dif_r = bin_dif[7:0];

  // decimal add: adjust each digit above 9 by 6
  assign add_lo     = {2'b00, a_i[3:0]} + {2'b00, v_i[3:0]} + {5'd0, cin_i};
  assign add_lo_adj = (add_lo > 6'd9) ? add_lo + 6'd6 : add_lo;
  assign add_hi     = {1'b0, a_i[7:4]} + {1'b0, v_i[7:4]} + {4'd0, (add_lo_adj > 6'd15)};
  assign add_cy     = add_hi > 5'd9;
  assign add_hi_r   = add_cy ? add_hi[3:0] + 4'd6 : add_hi[3:0];
  assign dec_sum    = {add_hi_r, add_lo_adj[3:0]};

  // decimal subtract: 5-bit two's complement digits, bit 4 marks a borrow
  always_comb begin
    sub_lo = {1'b0, a_i[3:0]} - {1'b0, v_i[3:0]} - {4'd0, ~cin_i};
    sub_hi = {1'b0, a_i[7:4]} - {1'b0, v_i[7:4]};
    if (sub_lo[4]) begin
      sub_lo = sub_lo - 5'd6;
      sub_hi = sub_hi - 5'd1;
    end
    if (sub_hi[4]) begin
      sub_hi = sub_hi - 5'd6;
    end
    sub_lo_r = sub_lo[3:0];
    sub_hi_r = sub_hi[3:0];
  end

  assign add_r = dec_i ? dec_sum : bin_sum[7:0];

  always_comb begin
    if (sub_i) begin
      out_o.res = dec_i ? {sub_hi_r, sub_lo_r} : bin_dif_r;
      out_o.c   = ~bin_dif[8];
      out_o.v   = (a_i[7] ^ v_i[7]) & (a_i[7] ^ bin_dif_r[7]);
    end else begin
      out_o.res = add_r;
      out_o.c   = dec_i ? add_cy : bin_sum[8];
      // decimal V comes from the adjusted result
      out_o.v   = ~(a_i[7] ^ v_i[7]) & (a_i[7] ^ add_r[7]);
    end
  end

endmodule

// File: rtl/core/alubcd_exec.sv
// Single-pass ALU datapath: operation decode, shifts, logic ops and flag update.
// Depends on alubcd_pkg and alubcd_addsub.
module alubcd_exec (
  input  alubcd_pkg::alu_op_e op_i,
  input  logic [7:0]          a_i,
  input  logic [7:0]          v_i,
  input  logic [7:0]          p_i,
  output logic [7:0]          res_o,
  output logic [7:0]          p_o
);
  import alubcd_pkg::*;

  addsub_t    as_out;
  logic [7:0] cmp_dif;
  logic [7:0] r;
  logic [7:0] p;
  logic       nz_upd;

  alubcd_addsub u_addsub (
    .sub_i (op_i == OP_SBC),
    .dec_i (p_i[FlagD]),
    .cin_i (p_i[FlagC]),
    .a_i   (a_i),
    .v_i   (v_i),
    .out_o (as_out)
  );

  assign cmp_dif = a_i - v_i;

  always_comb begin
    r      = a_i;
    p      = p_i;
    nz_upd = 1'b1;
    case (op_i)
      OP_ADC, OP_SBC: begin
        r        = as_out.res;
        p[FlagC] = as_out.c;
        p[FlagV] = as_out.v;
      end
      OP_CMP: begin
        p[FlagC] = a_i >= v_i;
        r        = a_i;
      end
      OP_BIT: begin
        nz_upd   = 1'b0;
        p[FlagZ] = (a_i & v_i) == 8'h00;
        p[FlagN] = v_i[7];
        p[FlagV] = v_i[6];
      end
      OP_BITIMM, OP_TRB, OP_TSB: begin
        nz_upd   = 1'b0;
        p[FlagZ] = (a_i & v_i) == 8'h00;
        if (op_i == OP_TRB) begin
          r = v_i & ~a_i;
        end else if (op_i == OP_TSB) begin
          r = v_i | a_i;
        end
      end
      OP_ASL: begin
        p[FlagC] = v_i[7];
        r        = {v_i[6:0], 1'b0};
      end
      OP_LSR: begin
        p[FlagC] = v_i[0];
        r        = {1'b0, v_i[7:1]};
      end
      OP_ROL: begin
        p[FlagC] = v_i[7];
        r        = {v_i[6:0], p_i[FlagC]};
      end
      OP_ROR: begin
        p[FlagC] = v_i[0];
        r        = {p_i[FlagC], v_i[7:1]};
      end
      OP_ORA:  r = a_i | v_i;
      OP_AND:  r = a_i & v_i;
      OP_EOR:  r = a_i ^ v_i;
      OP_INC:  r = v_i + 8'd1;
      OP_DEC:  r = v_i - 8'd1;
      default: nz_upd = 1'b0;
    endcase
    if (nz_upd) begin
      // CMP sets N/Z from the difference, not from the passed-through register
      p[FlagZ] = (op_i == OP_CMP) ? (cmp_dif == 8'h00) : (r == 8'h00);
      p[FlagN] = (op_i == OP_CMP) ? cmp_dif[7] : r[7];
    end
  end

  assign res_o = r;
  assign p_o   = p;

endmodule

// File: rtl/core/cmos_8bit_alu_bcd_top.sv
// 8-bit ALU with decimal mode: top level with operand and result registers.
// Depends on alubcd_pkg and alubcd_exec.
//
// Usage:
//   Command channel: start_i with action_i, register_in_i, operand_i and
//   flags_in_i. A command transfers at a rising edge with start_i high and
//   busy_o low. busy_o stays low, so a command can transfer every cycle.
//   Result channel: done_o marks result_o and flags_out_o for exactly one
//   cycle; the receiver takes the transfer at the edge that ends it and
//   cannot stall the block.
//   Timing: a command that transfers is held in the operand register, computed
//   from it combinationally and captured in the result register; done_o goes
//   high together with the captured result.
//   Throughput: one command per cycle, set by the single ALU pass between the
//   operand register and the result register.
//   Reset: rst_ni low clears the valid flags of both stages; no result is
//   delivered for a command in flight when reset asserts.
module cmos_8bit_alu_bcd_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [3:0] action_i,
  input  logic [7:0] register_in_i,
  input  logic [7:0] operand_i,
  input  logic [7:0] flags_in_i,
  output logic       done_o,
  output logic [7:0] result_o,
  output logic [7:0] flags_out_o
);
  import alubcd_pkg::*;

  logic       in_vld_q;
  alu_op_e    op_q;
  logic [7:0] a_q;
  logic [7:0] v_q;
  logic [7:0] p_q;
  logic [7:0] res_d;
  logic [7:0] p_d;
  logic       done_q;
  logic [7:0] res_q;
  logic [7:0] flags_q;
  logic       accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= accept;
      done_q   <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= alu_op_e'(action_i);
      a_q  <= register_in_i;
      v_q  <= operand_i;
      p_q  <= flags_in_i;
    end
  end

  alubcd_exec u_exec (
    .op_i  (op_q),
    .a_i   (a_q),
    .v_i   (v_q),
    .p_i   (p_q),
    .res_o (res_d),
    .p_o   (p_d)
  );

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q   <= res_d;
      flags_q <= p_d;
    end
  end

  assign done_o      = done_q;
  assign result_o    = res_q;
  assign flags_out_o = flags_q;

endmodule

// File: rtl/core/alubcd_check.sv
// Port-level checker for the 8-bit ALU top level, with its bind statement.
// Depends on alubcd_pkg and cmos_8bit_alu_bcd_top.
module alubcd_check (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [3:0] action_i,
  input logic [7:0] register_in_i,
  input logic [7:0] flags_in_i,
  input logic       done_o,
  input logic [7:0] result_o,
  input logic [7:0] flags_out_o
);
  import alubcd_pkg::*;

  logic accept;
  assign accept = start_i & ~busy_o;

  // every transfer yields a result once it has passed the operand and result registers
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("result missing two cycles after command transfer");

  // no result without a matching earlier command
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result without a matching command");

  // status bits 5 to 2, D among them, pass through
  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 (flags_out_o[5:2] == $past(flags_in_i[5:2], 2)))
    else $error("untouched status bits changed");

  // compare and bit test return the register unchanged
  a_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action_i == OP_CMP || action_i == OP_BIT || action_i == OP_BITIMM))
    |-> ##2 (result_o == $past(register_in_i, 2)))
    else $error("compare/bit test altered the register");

endmodule

bind cmos_8bit_alu_bcd_top alubcd_check u_alubcd_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .action_i      (action_i),
  .register_in_i (register_in_i),
  .flags_in_i    (flags_in_i),
  .done_o        (done_o),
  .result_o      (result_o),
  .flags_out_o   (flags_out_o)
);

// File: test/cmos_8bit_alu_bcd_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for cmos_8bit_alu_bcd_top: a queue-fed command driver and a result
// monitor, checked against an in-bench model of the binary/decimal ALU.
// Depends on alubcd_pkg and the cmos_8bit_alu_bcd_top RTL.
module cmos_8bit_alu_bcd_top_tb;
  import alubcd_pkg::*;

  typedef struct {
    alu_op_e     action;
    logic [7:0]  acc;
    logic [7:0]  operand;
    logic [7:0]  flags;
    int unsigned gap_pct;   // chance in 100 that the driver idles before this command
  } alu_cmd_t;

  typedef struct {
    logic [7:0] result;
    logic [7:0] flags;
  } alu_res_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       start_i       = 1'b0;
  logic [3:0] action_i      = '0;
  logic [7:0] register_in_i = '0;
  logic [7:0] operand_i     = '0;
  logic [7:0] flags_in_i    = '0;
  logic       busy_o;
  logic       done_o;
  logic [7:0] result_o;
  logic [7:0] flags_out_o;

  alu_cmd_t pending_cmds[$];
  alu_res_t expected_res[$];
  alu_cmd_t cmd_on_bus;
  int unsigned err_cnt = 0;

  cmos_8bit_alu_bcd_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .register_in_i (register_in_i),
    .operand_i     (operand_i),
    .flags_in_i    (flags_in_i),
    .done_o        (done_o),
    .result_o      (result_o),
    .flags_out_o   (flags_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] with_nz(logic [7:0] p, logic [7:0] r);
    p[FlagZ] = (r == 8'h00);
    p[FlagN] = r[7];
    return p;
  endfunction

  function automatic alu_res_t alu_predict(alu_cmd_t c);
    logic [7:0] a, v, p, r, ovf, br;
    logic       cin;
    logic [8:0] sum;
    int         lo, hi, diff;
    alu_res_t   res;
    a   = c.acc;
    v   = c.operand;
    p   = c.flags;
    cin = p[FlagC];
    r   = a;
    case (c.action)
      OP_ADC: begin
        if (!p[FlagD]) begin
          sum = {1'b0, a} + {1'b0, v} + {8'h00, cin};
          r = sum[7:0];
          p[FlagC] = sum[8];
        end else begin
          // nibble adjust as it stands, even for non-BCD digits
          lo = int'(a[3:0]) + int'(v[3:0]) + int'(cin);
          if (lo > 9) lo += 6;
          hi = int'(a[7:4]) + int'(v[7:4]) + ((lo > 15) ? 1 : 0);
          p[FlagC] = (hi > 9);
          if (hi > 9) hi += 6;
          r = 8'(((hi & 15) << 4) | (lo & 15));
        end
        ovf = ~(a ^ v) & (a ^ r);
        p[FlagV] = ovf[7];
        p = with_nz(p, r);
      end
      OP_SBC: begin
        // C and V always come from the binary difference
        diff = int'(a) - int'(v) - int'(!cin);
        br = 8'(diff);
        ovf = (a ^ v) & (a ^ br);
        p[FlagV] = ovf[7];
        p[FlagC] = (diff >= 0);
        if (!p[FlagD]) begin
          r = br;
        end else begin
          lo = int'(a[3:0]) - int'(v[3:0]) - int'(!cin);
          hi = int'(a[7:4]) - int'(v[7:4]);
          if (lo < 0) begin
            lo -= 6;
            hi -= 1;
          end
          if (hi < 0) hi -= 6;
          r = 8'(((hi & 15) << 4) | (lo & 15));
        end
        p = with_nz(p, r);
      end
      OP_CMP: begin
        p[FlagC] = (a >= v);
        p = with_nz(p, 8'(a - v));
      end
      OP_BIT: begin
        p[FlagZ] = ((a & v) == 8'h00);
        p[FlagN] = v[7];
        p[FlagV] = v[6];
      end
      OP_BITIMM: p[FlagZ] = ((a & v) == 8'h00);
      OP_ASL: begin
        p[FlagC] = v[7];
        r = {v[6:0], 1'b0};
        p = with_nz(p, r);
      end
      OP_LSR: begin
        p[FlagC] = v[0];
        r = {1'b0, v[7:1]};
        p = with_nz(p, r);
      end
      OP_ROL: begin
        p[FlagC] = v[7];
        r = {v[6:0], cin};
        p = with_nz(p, r);
      end
      OP_ROR: begin
        p[FlagC] = v[0];
        r = {cin, v[7:1]};
        p = with_nz(p, r);
      end
      OP_ORA: begin
        r = a | v;
        p = with_nz(p, r);
      end
      OP_AND: begin
        r = a & v;
        p = with_nz(p, r);
      end
      OP_EOR: begin
        r = a ^ v;
        p = with_nz(p, r);
      end
      OP_INC: begin
        r = v + 8'd1;
        p = with_nz(p, r);
      end
      OP_DEC: begin
        r = v - 8'd1;
        p = with_nz(p, r);
      end
      OP_TRB: begin
        p[FlagZ] = ((a & v) == 8'h00);
        r = v & ~a;
      end
      default: begin // OP_TSB
        p[FlagZ] = ((a & v) == 8'h00);
        r = v | a;
      end
    endcase
    res.result = r;
    res.flags  = p;
    return res;
  endfunction

  task automatic queue_cmd(alu_op_e op, logic [7:0] a, logic [7:0] v, logic [7:0] p,
                           int unsigned gap);
    alu_cmd_t c;
    c.action  = op;
    c.acc     = a;
    c.operand = v;
    c.flags   = p;
    c.gap_pct = gap;
    pending_cmds.push_back(c);
  endtask

  // mostly fully random; a third of ADC/SBC get valid BCD digits with D set
  task automatic queue_random_cmd(int unsigned gap);
    alu_op_e    op;
    logic [7:0] a, v, p;
    op = alu_op_e'($urandom_range(15));
    a  = 8'($urandom);
    v  = 8'($urandom);
    p  = 8'($urandom);
    if ((op == OP_ADC || op == OP_SBC) && $urandom_range(2) == 0) begin
      a = {4'($urandom_range(9)), 4'($urandom_range(9))};
      v = {4'($urandom_range(9)), 4'($urandom_range(9))};
      p[FlagD] = 1'b1;
    end
    queue_cmd(op, a, v, p, gap);
  endtask

  task automatic log_error(string msg);
    if (err_cnt < 10) $display("%t ERROR: %s", $realtime, msg);
    err_cnt++;
  endtask

  // command driver: one transfer per edge with start high and busy low
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) expected_res.push_back(alu_predict(cmd_on_bus));
      if (!start_i || !busy_o) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= pending_cmds[0].gap_pct) begin
          cmd_on_bus    = pending_cmds.pop_front();
          start_i       <= 1'b1;
          action_i      <= cmd_on_bus.action;
          register_in_i <= cmd_on_bus.acc;
          operand_i     <= cmd_on_bus.operand;
          flags_in_i    <= cmd_on_bus.flags;
        end else begin
          // idle: scramble the payload so stale data cannot pass
          start_i       <= 1'b0;
          action_i      <= 4'($urandom);
          register_in_i <= 8'($urandom);
          operand_i     <= 8'($urandom);
          flags_in_i    <= 8'($urandom);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    alu_res_t e;
    if (rst_ni && done_o) begin
      if (expected_res.size() == 0) begin
        log_error($sformatf("result with none expected: result=%02h flags=%02h",
                            result_o, flags_out_o));
      end else begin
        e = expected_res.pop_front();
        if (result_o !== e.result)
          log_error($sformatf("result: expected %02h, got %02h", e.result, result_o));
        if (flags_out_o !== e.flags)
          log_error($sformatf("flags: expected %02h, got %02h", e.flags, flags_out_o));
      end
    end
  end

  initial begin
    int unsigned gaps[4] = '{0, 77, 0, 25};

    // directed: field extremes, every operation, decimal corner cases
    queue_cmd(OP_ADC,    8'h7F, 8'h01, 8'h00, 0);  // signed overflow
    queue_cmd(OP_ADC,    8'hFF, 8'h01, 8'h00, 0);  // carry out, zero
    queue_cmd(OP_ADC,    8'hFF, 8'hFF, 8'hFF, 0);  // all ones, D set, non-BCD
    queue_cmd(OP_ADC,    8'h99, 8'h01, 8'h08, 0);  // decimal wrap to 00
    queue_cmd(OP_ADC,    8'h58, 8'h46, 8'h09, 0);  // decimal with carry in
    queue_cmd(OP_ADC,    8'h0F, 8'h0A, 8'h08, 0);  // decimal non-BCD low digit
    queue_cmd(OP_SBC,    8'h00, 8'h01, 8'h01, 0);  // binary borrow
    queue_cmd(OP_SBC,    8'h80, 8'h01, 8'h01, 0);  // signed overflow
    queue_cmd(OP_SBC,    8'h00, 8'h01, 8'h09, 0);  // decimal borrow to 99
    queue_cmd(OP_SBC,    8'h0A, 8'hFF, 8'h08, 0);  // decimal non-BCD, no carry in
    queue_cmd(OP_SBC,    8'h00, 8'h00, 8'h00, 0);  // all zeros
    queue_cmd(OP_CMP,    8'h40, 8'h40, 8'h00, 0);
    queue_cmd(OP_CMP,    8'h00, 8'hFF, 8'hFF, 0);
    queue_cmd(OP_BIT,    8'h00, 8'hC0, 8'h00, 0);
    queue_cmd(OP_BITIMM, 8'h0F, 8'hF0, 8'h00, 0);  // only Z may change
    queue_cmd(OP_ASL,    8'h00, 8'h80, 8'h00, 0);
    queue_cmd(OP_LSR,    8'h00, 8'h01, 8'h00, 0);
    queue_cmd(OP_ROL,    8'h00, 8'h80, 8'h01, 0);
    queue_cmd(OP_ROR,    8'h00, 8'h01, 8'h01, 0);
    queue_cmd(OP_ORA,    8'h00, 8'h00, 8'hFF, 0);
    queue_cmd(OP_AND,    8'hFF, 8'h80, 8'h00, 0);
    queue_cmd(OP_EOR,    8'hAA, 8'hAA, 8'h00, 0);
    queue_cmd(OP_INC,    8'h00, 8'hFF, 8'h00, 0);  // wraps
    queue_cmd(OP_DEC,    8'h00, 8'h00, 8'h00, 0);  // wraps
    queue_cmd(OP_TRB,    8'hF0, 8'hFF, 8'h00, 0);
    queue_cmd(OP_TSB,    8'h0F, 8'hF0, 8'hFF, 0);

    foreach (gaps[i]) begin
      repeat (270) queue_random_cmd(gaps[i]);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() > 0 || start_i || expected_res.size() > 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("cmos_8bit_alu_bcd_top_tb: PASS");
    end else begin
      $display("cmos_8bit_alu_bcd_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("cmos_8bit_alu_bcd_top_tb: FAIL");
    $finish;
  end

endmodule
